// File: rtl/core/htpe_pkg.sv
// package: shared types and codes of the hash table probe engine
package htpe_pkg;
  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_LOOKUP = 2'd1;
  localparam logic [1:0] CMD_DELETE = 2'd2;
  localparam logic [1:0] CMD_NOP    = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_DUP     = 2'd2;
  localparam logic [1:0] ST_MISSING = 2'd3;

  localparam int CFG_IDX_BITS  = 1;
  localparam int CFG_DATA_BITS = 7;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MODE = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SIZE = 1'd1;

  localparam int STATUS_BITS = 2;
  localparam int CMD_BITS    = 2;
  localparam int LEN_BITS    = 4;
  localparam int COUNT_BITS  = 7;
  localparam int COLL_BITS   = 32;
  localparam int KEYW_BITS   = 64;
  localparam int VALW_BITS   = 32;

  typedef struct packed {
    logic [CMD_BITS-1:0]  command;
    logic [KEYW_BITS-1:0] key_bytes;
    logic [LEN_BITS-1:0]  key_length;
    logic [VALW_BITS-1:0] value_in;
  } req_t;

  typedef struct packed {
    logic [STATUS_BITS-1:0] status;
    logic [VALW_BITS-1:0]   value_out;
    logic [COUNT_BITS-1:0]  entry_count;
    logic [COLL_BITS-1:0]   collision_count;
  } rsp_t;
endpackage

// File: rtl/core/htpe_if.sv
// interfaces: request and response channels
interface htpe_req_if;
  logic valid;
  logic ready;
  htpe_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface htpe_rsp_if;
  logic valid;
  logic ready;
  htpe_pkg::rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/core/hash_table_probe_engine.sv
// top level: keyed table engine with linear probing; mode 0 uses the home slot only
// steps: sum the key bytes, reduce the sum modulo the table size, read the home slot,
// probe further slots if needed, finish and present the response
// probes: insert tests each slot in a check state; lookup and delete also pass an addr
// state per slot, as the slot read is registered; one request is taken at a time
// reset clears occupancy flags and counters, sets mode 1 and size 64, not slot memories
module hash_table_probe_engine #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  htpe_req_if.sink   req,
  htpe_rsp_if.source rsp,
  input  logic                               cfg_we_i,
  input  logic [htpe_pkg::CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [htpe_pkg::CFG_DATA_BITS-1:0] cfg_data_i
);
  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  localparam logic [3:0] S_IDLE = 4'd0, S_SUM = 4'd1, S_MOD = 4'd2, S_HOME = 4'd3,
                         S_HWAIT = 4'd4, S_RADDR = 4'd5, S_RCHK = 4'd6,
                         S_LADDR = 4'd7, S_LCHK = 4'd8, S_DONE = 4'd9, S_OUT = 4'd10;

  logic [3:0] st_q, st_d;
  logic mode_q;
  logic [6:0] size_q;
  logic [TABLE_DEPTH-1:0] occ_q;
  logic [CW-1:0] cnt_q;
  logic [31:0] coll_q;

  logic [63:0] kmem [TABLE_DEPTH];
  logic [3:0]  lmem [TABLE_DEPTH];
  logic [31:0] vmem [TABLE_DEPTH];
  logic [63:0] rk_q;
  logic [3:0]  rl_q;
  logic [31:0] rv_q;

  logic [1:0]  cmd_q;
  logic [63:0] key_q;
  logic [3:0]  len_q;
  logic [31:0] val_q;
  logic [10:0] sum_q;
  logic [3:0]  bi_q;
  logic [AW-1:0] home_q, ptr_q;
  logic [CW-1:0] esize;
  logic [1:0]  stat_q;
  logic [31:0] fnd_q;
  logic mod_start, mod_done;
  logic [10:0] mod_rem;
  htpe_pkg::rsp_t rsp_q;

  // write request issued in S_DONE
  logic wr_q;
  logic clr_q;
  logic [CW-1:0] cnt_nx;

  assign cnt_nx = (wr_q && !occ_q[ptr_q]) ? cnt_q + CW'(1) :
                  clr_q ? cnt_q - CW'(1) : cnt_q;

  assign esize = (size_q == 7'd0) ? CW'(1) :
                 ({25'd0, size_q} > 32'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : CW'(size_q);

  htpe_mod u_mod (
    .clk_i, .rst_ni, .start_i(mod_start), .sum_i(sum_q),
    .size_i(7'(esize)),
    .done_o(mod_done), .rem_o(mod_rem)
  );

  logic match;
  assign match = occ_q[ptr_q] && rl_q == len_q && rk_q == key_q;

  assign req.ready = (st_q == S_IDLE);
  assign rsp.valid = (st_q == S_OUT);
  assign rsp.data  = rsp_q;
  assign mod_start = (st_q == S_SUM) && (bi_q >= len_q);

  logic [3:0] len_c;
  logic [63:0] key_c;
  always_comb begin
    len_c = (req.data.key_length > 4'd8) ? 4'd8 : req.data.key_length;
    key_c = req.data.key_bytes;
    for (int i = 0; i < 8; i++)
      if (4'(i) >= len_c) key_c[i*8 +: 8] = 8'd0;
  end

  // slot memory read and write port
  always_ff @(posedge clk_i) begin
    rk_q <= kmem[ptr_q];
    rl_q <= lmem[ptr_q];
    rv_q <= vmem[ptr_q];
    if (wr_q) begin
      kmem[ptr_q] <= key_q;
      lmem[ptr_q] <= len_q;
      vmem[ptr_q] <= val_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
      mode_q <= 1'b1;
      size_q <= 7'd64;
      occ_q <= '0;
      cnt_q <= '0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == htpe_pkg::CFG_MODE) mode_q <= cfg_data_i[0];
        if (cfg_idx_i == htpe_pkg::CFG_SIZE) size_q <= cfg_data_i;
      end
      if (wr_q) occ_q[ptr_q] <= 1'b1;
      if (clr_q) occ_q[ptr_q] <= 1'b0;
      cnt_q <= cnt_nx;
      st_q <= st_d;
    end
  end

  logic bump;
  logic [1:0] stat_d;
  logic [31:0] fnd_d;
  logic wr_d, clr_d;
  logic [AW-1:0] ptr_d;
  always_comb begin
    st_d = st_q; bump = 1'b0; stat_d = stat_q; fnd_d = fnd_q;
    wr_d = 1'b0; clr_d = 1'b0; ptr_d = ptr_q;
    case (st_q)
      S_IDLE:  if (req.valid) st_d = S_SUM;
      S_SUM:   if (bi_q >= len_q) st_d = S_MOD;
      S_MOD:   if (mod_done) begin
        st_d = S_HOME; ptr_d = AW'(mod_rem);
      end
      S_HOME:  st_d = S_HWAIT;
      S_HWAIT: begin
        st_d = S_DONE;
        if (!mode_q) begin
          if (cmd_q == htpe_pkg::CMD_INSERT) begin
            bump = occ_q[ptr_q]; wr_d = 1'b1;
          end else if (cmd_q == htpe_pkg::CMD_LOOKUP || cmd_q == htpe_pkg::CMD_DELETE) begin
            if (!occ_q[ptr_q]) stat_d = htpe_pkg::ST_MISSING;
            else if (cmd_q == htpe_pkg::CMD_LOOKUP) fnd_d = rv_q;
            else clr_d = 1'b1;
          end
        end else if (cmd_q == htpe_pkg::CMD_INSERT) begin
          if (cnt_q >= esize) stat_d = htpe_pkg::ST_FULL;
          else if (!occ_q[ptr_q]) wr_d = 1'b1;
          else if (match) stat_d = htpe_pkg::ST_DUP;
          else begin
            bump = 1'b1;
            if (CW'(ptr_q) + CW'(1) < esize) begin
              ptr_d = ptr_q + AW'(1); st_d = S_RCHK;
            end else if (home_q != '0) begin
              ptr_d = home_q - AW'(1); st_d = S_LCHK;
            end else stat_d = htpe_pkg::ST_FULL;
          end
        end else if (cmd_q == htpe_pkg::CMD_LOOKUP || cmd_q == htpe_pkg::CMD_DELETE) begin
          if (!occ_q[ptr_q]) stat_d = htpe_pkg::ST_MISSING;
          else if (match) begin
            if (cmd_q == htpe_pkg::CMD_LOOKUP) fnd_d = rv_q; else clr_d = 1'b1;
          end else if (CW'(ptr_q) + CW'(1) < esize) begin
            ptr_d = ptr_q + AW'(1); st_d = S_RCHK;
          end else if (home_q != '0) begin
            ptr_d = home_q - AW'(1); st_d = S_LCHK;
          end else stat_d = htpe_pkg::ST_MISSING;
        end
      end
      S_RADDR: st_d = S_RCHK;
      S_LADDR: st_d = S_LCHK;
      S_RCHK, S_LCHK: begin
        // memory read of ptr_q is registered: lookup and delete wait via the addr state first
        st_d = S_DONE;
        if (cmd_q == htpe_pkg::CMD_INSERT) begin
          if (!occ_q[ptr_q]) wr_d = 1'b1;
          else if (st_q == S_RCHK && CW'(ptr_q) + CW'(1) < esize) begin
            ptr_d = ptr_q + AW'(1); st_d = S_RCHK;
          end else if (st_q == S_RCHK && home_q != '0) begin
            ptr_d = home_q - AW'(1); st_d = S_LCHK;
          end else if (st_q == S_LCHK && ptr_q != '0) begin
            ptr_d = ptr_q - AW'(1); st_d = S_LCHK;
          end else stat_d = htpe_pkg::ST_FULL;
        end else begin
          st_d = (st_q == S_RCHK) ? S_RADDR : S_LADDR;
        end
      end
      S_DONE:  st_d = S_OUT;
      S_OUT:   if (rsp.ready) st_d = S_IDLE;
      default: st_d = S_IDLE;
    endcase
    // key search: the addr state of each lookup or delete probe compares registered read data
    if ((st_q == S_RADDR || st_q == S_LADDR) && cmd_q != htpe_pkg::CMD_INSERT) begin
      if (match) begin
        st_d = S_DONE;
        if (cmd_q == htpe_pkg::CMD_LOOKUP) fnd_d = rv_q; else clr_d = 1'b1;
      end else if (st_q == S_RADDR && CW'(ptr_q) + CW'(1) < esize) begin
        ptr_d = ptr_q + AW'(1); st_d = S_RCHK;
      end else if (st_q == S_RADDR && home_q != '0) begin
        ptr_d = home_q - AW'(1); st_d = S_LCHK;
      end else if (st_q == S_LADDR && ptr_q != '0) begin
        ptr_d = ptr_q - AW'(1); st_d = S_LCHK;
      end else begin
        st_d = S_DONE; stat_d = htpe_pkg::ST_MISSING;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stat_q <= htpe_pkg::ST_OK;
      coll_q <= '0;
      wr_q <= 1'b0;
      clr_q <= 1'b0;
    end else begin
      if (st_q == S_IDLE) stat_q <= htpe_pkg::ST_OK;
      else stat_q <= stat_d;
      if (bump && coll_q != 32'hFFFF_FFFF) coll_q <= coll_q + 32'd1;
      wr_q <= wr_d;
      clr_q <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q <= ptr_d;
    fnd_q <= (st_q == S_IDLE) ? 32'd0 : fnd_d;
    if (st_q == S_IDLE && req.valid) begin
      cmd_q <= req.data.command;
      key_q <= key_c;
      len_q <= len_c;
      val_q <= req.data.value_in;
      sum_q <= '0;
      bi_q  <= '0;
    end
    if (st_q == S_SUM && bi_q < len_q) begin
      sum_q <= sum_q + {3'd0, key_q[bi_q[2:0]*8 +: 8]};
      bi_q  <= bi_q + 4'd1;
    end
    if (st_q == S_MOD && mod_done) home_q <= AW'(mod_rem);
    if (st_q == S_DONE) begin
      rsp_q.status          <= stat_q;
      rsp_q.value_out       <= fnd_q;
      rsp_q.entry_count     <= 7'(cnt_nx);
      rsp_q.collision_count <= coll_q;
    end
  end
endmodule

// File: rtl/core/htpe_mod.sv
// iterative reduction of the key byte sum modulo the table size
module htpe_mod (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [10:0] sum_i,
  input  logic [6:0]  size_i,
  output logic        done_o,
  output logic [10:0] rem_o
);
  logic [10:0] rem_q, rem_d;
  logic [3:0]  sh_q, sh_d;
  logic        busy_q, busy_d;
  logic [17:0] sub;

  assign sub = {11'd0, size_i} << sh_q;

  always_comb begin
    rem_d  = rem_q;
    sh_d   = sh_q;
    busy_d = busy_q;
    done_o = 1'b0;
    if (start_i) begin
      rem_d  = sum_i;
      sh_d   = 4'd10;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if ({7'd0, rem_q} >= sub) rem_d = rem_q - sub[10:0];
      if (sh_q == 4'd0) begin
        busy_d = 1'b0;
        done_o = 1'b1;
      end else begin
        sh_d = sh_q - 4'd1;
      end
    end
  end

  assign rem_o = rem_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      sh_q   <= '0;
    end else begin
      busy_q <= busy_d;
      sh_q   <= sh_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
  end
endmodule

// File: verif/tb_hash_table_probe_engine.sv
// testbench: random and directed requests against a self-checking table model
module tb_hash_table_probe_engine;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 64;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [htpe_pkg::CFG_IDX_BITS-1:0] cfg_idx_i = '0;
  logic [htpe_pkg::CFG_DATA_BITS-1:0] cfg_data_i = '0;

  htpe_req_if req ();
  htpe_rsp_if rsp ();

  hash_table_probe_engine #(.TABLE_DEPTH(DEPTH)) dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .req(req.sink), .rsp(rsp.source),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shadow table
  logic [63:0] tbl_key [DEPTH];
  logic [3:0]  tbl_len [DEPTH];
  logic [31:0] tbl_val [DEPTH];
  logic        tbl_used [DEPTH];
  int unsigned tbl_total;
  logic [31:0] tbl_coll;
  logic        tbl_mode;
  logic [6:0]  tbl_size;

  htpe_pkg::req_t pending_q[$];
  htpe_pkg::rsp_t expected_q[$];
  int   err_cnt = 0;
  bit   no_gaps = 1'b0;
  bit   long_hold_go = 1'b0;
  bit   hold_active = 1'b0;
  bit   hold_done = 1'b0;
  int   hold_cnt = 0;

  logic [63:0] key_pool [24];
  logic [3:0]  len_pool [24];

  function automatic bit key_hit(int s, logic [63:0] k, logic [3:0] l);
    return tbl_used[s] && tbl_len[s] == l && tbl_key[s] == k;
  endfunction

  function automatic void store_slot(int s, logic [63:0] k, logic [3:0] l, logic [31:0] v);
    if (!tbl_used[s]) tbl_total++;
    tbl_used[s] = 1'b1;
    tbl_key[s] = k;
    tbl_len[s] = l;
    tbl_val[s] = v;
  endfunction

  function automatic void bump_coll();
    if (tbl_coll != 32'hFFFF_FFFF) tbl_coll++;
  endfunction

  function automatic htpe_pkg::rsp_t predict_probe(htpe_pkg::req_t r);
    logic [63:0] k;
    logic [3:0] l;
    int sz, sum, home, s, hit;
    htpe_pkg::rsp_t o;
    o = '0;
    o.status = htpe_pkg::ST_OK;
    l = (r.key_length > 4'd8) ? 4'd8 : r.key_length;
    k = '0;
    sum = 0;
    for (int b = 0; b < l; b++) begin
      k[8*b +: 8] = r.key_bytes[8*b +: 8];
      sum += r.key_bytes[8*b +: 8];
    end
    sz = (tbl_size == 0) ? 1 : ((tbl_size > DEPTH) ? DEPTH : tbl_size);
    home = sum % sz;
    if (!tbl_mode) begin
      if (r.command == htpe_pkg::CMD_INSERT) begin
        if (tbl_used[home]) bump_coll();
        store_slot(home, k, l, r.value_in);
      end else if (r.command == htpe_pkg::CMD_LOOKUP || r.command == htpe_pkg::CMD_DELETE) begin
        if (!tbl_used[home]) o.status = htpe_pkg::ST_MISSING;
        else if (r.command == htpe_pkg::CMD_LOOKUP) o.value_out = tbl_val[home];
        else begin
          tbl_used[home] = 1'b0;
          tbl_total--;
        end
      end
    end else if (r.command == htpe_pkg::CMD_INSERT) begin
      if (tbl_total >= sz) o.status = htpe_pkg::ST_FULL;
      else if (!tbl_used[home]) store_slot(home, k, l, r.value_in);
      else if (key_hit(home, k, l)) o.status = htpe_pkg::ST_DUP;
      else begin
        bump_coll();
        for (s = home + 1; s < sz && tbl_used[s]; s++);
        if (s >= sz) begin
          for (s = home; s > 0 && tbl_used[s-1]; s--);
          s = (s > 0) ? s - 1 : sz;
        end
        if (s >= sz) o.status = htpe_pkg::ST_FULL;
        else store_slot(s, k, l, r.value_in);
      end
    end else if (r.command == htpe_pkg::CMD_LOOKUP || r.command == htpe_pkg::CMD_DELETE) begin
      hit = sz;
      if (tbl_used[home]) begin
        for (s = home; s < sz && hit == sz; s++) if (key_hit(s, k, l)) hit = s;
        for (s = home; s > 0 && hit == sz; s--) if (key_hit(s-1, k, l)) hit = s - 1;
      end
      if (hit >= sz) o.status = htpe_pkg::ST_MISSING;
      else if (r.command == htpe_pkg::CMD_LOOKUP) o.value_out = tbl_val[hit];
      else begin
        tbl_used[hit] = 1'b0;
        tbl_total--;
      end
    end
    o.entry_count = tbl_total[6:0];
    o.collision_count = tbl_coll;
    return o;
  endfunction

  // driver
  int src_gap = 0;
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      req.valid <= 1'b0;
      req.data <= '0;
    end else begin
      if (req.valid && req.ready) expected_q.push_back(predict_probe(req.data));
      if (!(req.valid && !req.ready)) begin
        if (src_gap > 0) begin
          src_gap <= src_gap - 1;
          req.valid <= 1'b0;
        end else if (pending_q.size() > 0) begin
          req.data <= pending_q.pop_front();
          req.valid <= 1'b1;
          src_gap <= no_gaps ? 0 : int'($urandom_range(0, 16));
        end else begin
          req.valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk_i) begin
    if (long_hold_go && !hold_done) begin
      hold_active <= 1'b1;
      hold_cnt <= hold_cnt + 1;
      if (hold_cnt >= 600) begin
        hold_done <= 1'b1;
        hold_active <= 1'b0;
      end
    end
  end

  // monitor
  int snk_gap = 0;
  always @(posedge clk_i) begin
    htpe_pkg::rsp_t e;
    if (!rst_ni) begin
      rsp.ready <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (expected_q.size() == 0) begin
          $display("%0t unexpected word: got %p", $realtime, rsp.data);
          err_cnt++;
        end else begin
          e = expected_q.pop_front();
          if (rsp.data.status !== e.status) begin
            $display("%0t status exp %0d got %0d", $realtime, e.status, rsp.data.status);
            err_cnt++;
          end
          if (rsp.data.value_out !== e.value_out) begin
            $display("%0t value_out exp %h got %h", $realtime, e.value_out, rsp.data.value_out);
            err_cnt++;
          end
          if (rsp.data.entry_count !== e.entry_count) begin
            $display("%0t entry_count exp %0d got %0d", $realtime, e.entry_count,
                     rsp.data.entry_count);
            err_cnt++;
          end
          if (rsp.data.collision_count !== e.collision_count) begin
            $display("%0t collision_count exp %0d got %0d", $realtime, e.collision_count,
                     rsp.data.collision_count);
            err_cnt++;
          end
        end
        snk_gap = no_gaps ? 0 : int'($urandom_range(0, 16));
        rsp.ready <= 1'b0;
      end else if (snk_gap > 0) begin
        snk_gap--;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= !hold_active;
      end
    end
  end

  task automatic add_req(logic [1:0] c, logic [63:0] k, logic [3:0] l, logic [31:0] v);
    htpe_pkg::req_t r;
    r.command = c;
    r.key_bytes = k;
    r.key_length = l;
    r.value_in = v;
    pending_q.push_back(r);
  endtask

  task automatic wait_idle();
    wait (pending_q.size() == 0 && !req.valid && expected_q.size() == 0);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic [htpe_pkg::CFG_IDX_BITS-1:0] idx, logic [6:0] d);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= d;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == htpe_pkg::CFG_MODE) tbl_mode = d[0];
    else tbl_size = d;
  endtask

  task automatic random_phase(int n);
    int p, pick;
    logic [1:0] c;
    logic [63:0] k;
    logic [3:0] l;
    for (int i = 0; i < n; i++) begin
      p = int'($urandom_range(0, 99));
      c = (p < 45) ? htpe_pkg::CMD_INSERT : (p < 72) ? htpe_pkg::CMD_LOOKUP :
          (p < 96) ? htpe_pkg::CMD_DELETE : htpe_pkg::CMD_NOP;
      pick = int'($urandom_range(0, 23));
      if ($urandom_range(0, 3) != 0) begin
        k = key_pool[pick];
        l = len_pool[pick];
      end else begin
        k = {$urandom, $urandom};
        l = 4'($urandom_range(0, 15));
      end
      add_req(c, k, l, $urandom);
    end
  endtask

  initial begin
    for (int s = 0; s < DEPTH; s++) tbl_used[s] = 1'b0;
    tbl_total = 0;
    tbl_coll = '0;
    tbl_mode = 1'b1;
    tbl_size = 7'd64;
    for (int i = 0; i < 24; i++) begin
      key_pool[i] = {$urandom, $urandom};
      len_pool[i] = (i < 20) ? 4'($urandom_range(1, 8)) : 4'($urandom_range(0, 15));
      if (i % 3 == 0) key_pool[i] = key_pool[i] & 64'h0000_0000_0000_0F0F;
    end
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed at reset settings
    add_req(htpe_pkg::CMD_INSERT, '1, 4'd8, '1);
    add_req(htpe_pkg::CMD_INSERT, '1, 4'd8, 32'h1234_5678);
    add_req(htpe_pkg::CMD_LOOKUP, '1, 4'd8, '0);
    add_req(htpe_pkg::CMD_LOOKUP, '1, 4'd7, '0);
    add_req(htpe_pkg::CMD_INSERT, 64'h0102, 4'd2, 32'hA);
    add_req(htpe_pkg::CMD_INSERT, 64'h0201, 4'd2, 32'hB);
    add_req(htpe_pkg::CMD_INSERT, 64'hFF03, 4'd1, 32'hC);
    add_req(htpe_pkg::CMD_LOOKUP, 64'h0201, 4'd2, '0);
    add_req(htpe_pkg::CMD_INSERT, 64'h3F, 4'd1, '0);
    add_req(htpe_pkg::CMD_INSERT, 64'h1F20, 4'd2, 32'hD);
    add_req(htpe_pkg::CMD_INSERT, 64'h1E21, 4'd2, 32'hE);
    add_req(htpe_pkg::CMD_LOOKUP, 64'h1E21, 4'd2, '0);
    add_req(htpe_pkg::CMD_INSERT, 64'hDEAD, 4'd0, 32'hF);
    add_req(htpe_pkg::CMD_INSERT, {$urandom, $urandom}, 4'd15, 32'h5);
    add_req(htpe_pkg::CMD_NOP, '1, 4'd8, '1);
    add_req(htpe_pkg::CMD_DELETE, 64'h0102, 4'd2, '0);
    add_req(htpe_pkg::CMD_DELETE, 64'h0102, 4'd2, '0);
    add_req(htpe_pkg::CMD_LOOKUP, 64'h0102, 4'd2, '0);
    add_req(htpe_pkg::CMD_DELETE, 64'h0201, 4'd2, '0);
    add_req(htpe_pkg::CMD_LOOKUP, 64'hFF03, 4'd1, '0);
    add_req(htpe_pkg::CMD_DELETE, 64'h77, 4'd1, '0);
    wait_idle();

    no_gaps = 1'b1;
    random_phase(60);
    wait (pending_q.size() < 40);
    long_hold_go = 1'b1;
    wait_idle();
    no_gaps = 1'b0;

    write_cfg(htpe_pkg::CFG_MODE, 7'd0);
    write_cfg(htpe_pkg::CFG_SIZE, 7'd64);
    random_phase(100);
    wait_idle();
    write_cfg(htpe_pkg::CFG_SIZE, 7'd3);
    random_phase(70);
    wait_idle();
    write_cfg(htpe_pkg::CFG_MODE, 7'd1);
    write_cfg(htpe_pkg::CFG_SIZE, 7'd0);
    random_phase(40);
    wait_idle();
    write_cfg(htpe_pkg::CFG_SIZE, 7'd127);
    random_phase(120);
    wait_idle();
    write_cfg(htpe_pkg::CFG_SIZE, 7'd5);
    random_phase(60);
    wait_idle();
    write_cfg(htpe_pkg::CFG_SIZE, 7'd64);
    no_gaps = 1'b1;
    random_phase(70);
    wait_idle();
    no_gaps = 1'b0;
    write_cfg(htpe_pkg::CFG_MODE, 7'd0);
    write_cfg(htpe_pkg::CFG_SIZE, 7'd1);
    random_phase(40);
    wait_idle();
    write_cfg(htpe_pkg::CFG_MODE, 7'd1);
    write_cfg(htpe_pkg::CFG_SIZE, 7'd17);
    random_phase(80);
    wait_idle();

    if (err_cnt == 0 && expected_q.size() == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #5ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule

// File: hash_table_probe_engine.f
rtl/core/htpe_pkg.sv
rtl/core/htpe_if.sv
rtl/core/htpe_mod.sv
rtl/core/hash_table_probe_engine.sv
verif/tb_hash_table_probe_engine.sv
